// ----- rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, widths and codes for the scanned switch debouncer.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Default number of scanned buttons
    localparam int NUM_BUTTONS_DEF = 3;

    // Fixed field widths
    localparam int PIN_W      = 3;   // pin_levels
    localparam int QRY_W      = 2;   // query_button
    localparam int EVB_W      = 2;   // event_button
    localparam int QST_W      = 3;   // query_state
    localparam int CNT_W      = 8;   // confirm count and threshold
    localparam int S_DATA_W   = 8;   // pin_levels + query_button, byte padded
    localparam int M_DATA_W   = 8;   // 7 result bits, byte padded
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register defaults
    localparam logic             ACTIVE_LOW_RST   = 1'b1;
    localparam logic [CNT_W-1:0] STABLE_COUNT_RST = 8'd20;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACTIVE_LOW   = 1'b0,
        CFG_STABLE_COUNT = 1'b1
    } cfg_addr_t;

    // Per-button debounce state, one-hot
    typedef enum logic [4:0] {
        ST_RELEASED = 5'b00001,
        ST_PREPUSH  = 5'b00010,
        ST_PUSHED   = 5'b00100,
        ST_PREREL   = 5'b01000,
        ST_ERROR    = 5'b10000
    } btn_state_t;

    // Reported state codes
    localparam logic [QST_W-1:0] QST_RELEASED = 3'd0;
    localparam logic [QST_W-1:0] QST_PREPUSH  = 3'd1;
    localparam logic [QST_W-1:0] QST_PUSHED   = 3'd2;
    localparam logic [QST_W-1:0] QST_PREREL   = 3'd3;
    localparam logic [QST_W-1:0] QST_ERROR    = 3'd4;

    function automatic logic [QST_W-1:0] state_code(input btn_state_t st);
        logic [QST_W-1:0] code;
        case (st)
            ST_RELEASED: code = QST_RELEASED;
            ST_PREPUSH:  code = QST_PREPUSH;
            ST_PUSHED:   code = QST_PUSHED;
            ST_PREREL:   code = QST_PREREL;
            default:     code = QST_ERROR;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/scanned_switch_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// scanned_switch_debouncer_top
// Each result beat is registered into the result register or the skid entry.
// Throughput: one input beat per cycle while s_tready is high; per-button
//   updates are all one pass of logic between state and result registers.
// A two-entry output stage (result register plus skid) keeps s_tready high
//   for one extra beat while the result side stalls.
// Reset (aresetn low, synchronous): every button goes to the error code with
//   count zero, scan restarts at button 0, config returns to active_low = 1,
//   stable_count = 20, and both output entries are emptied.
// ----------------------------------------------------------------------------
module scanned_switch_debouncer_top #(
    parameter int NUM_BUTTONS = ssd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ssd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] pin_levels, [4:3] query_button, [7:5] zero
    input  logic [ssd_pkg::S_DATA_W-1:0]        s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] press_event, [2:1] event_button, [3] scan_idle,
    // [6:4] query_state, [7] zero
    output logic [ssd_pkg::M_DATA_W-1:0]        m_tdata
);
    import ssd_pkg::*;

    // Scan index runs 0..NUM_BUTTONS; NUM_BUTTONS is the idle tick
    localparam int SCAN_W    = $clog2(NUM_BUTTONS + 1);
    localparam int PIN_EXT_W = NUM_BUTTONS + PIN_W;
    localparam int QRY_SPAN  = 1 << QRY_W;

    // ---------------- configuration ----------------
    logic             active_low_reg;
    logic [CNT_W-1:0] stable_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg   <= ACTIVE_LOW_RST;
            stable_count_reg <= STABLE_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_ACTIVE_LOW:   active_low_reg   <= cfg_wdata[0];
                CFG_STABLE_COUNT: stable_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input beat ----------------
    logic                 s_accept;
    logic [PIN_W-1:0]     pin_levels;
    logic [QRY_W-1:0]     query_button;
    logic [PIN_EXT_W-1:0] pin_ext;
    logic [NUM_BUTTONS-1:0] lane_level;

    assign s_accept     = s_tvalid && s_tready;
    assign pin_levels   = s_tdata[PIN_W-1:0];
    assign query_button = s_tdata[PIN_W +: QRY_W];
    // buttons past the pin field read level 0
    assign pin_ext      = PIN_EXT_W'(pin_levels);
    assign lane_level   = pin_ext[NUM_BUTTONS-1:0];

    // ---------------- scan and button lanes ----------------
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;
    logic              scan_idle;

    btn_state_t       state_reg  [NUM_BUTTONS];
    btn_state_t       state_next [NUM_BUTTONS];
    logic [CNT_W-1:0] count_reg  [NUM_BUTTONS];
    logic [CNT_W-1:0] count_next [NUM_BUTTONS];
    logic [CNT_W-1:0] count_inc  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] lane_pressed;
    logic [NUM_BUTTONS-1:0] lane_match;
    logic [NUM_BUTTONS-1:0] lane_confirm;
    logic [NUM_BUTTONS-1:0] lane_event;

    assign scan_idle = (scan_idx_reg == SCAN_W'(NUM_BUTTONS));

    always_comb begin
        scan_idx_next = scan_idx_reg;
        if (s_accept) begin
            scan_idx_next = scan_idle ? '0 : scan_idx_reg + SCAN_W'(1);
        end
    end

    // Each lane runs its own state machine; only the scanned lane advances.
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            lane_pressed[i] = lane_level[i] ^ active_low_reg;
            // pre-pushed counts pressed samples, pre-released counts released
            lane_match[i]   = (state_reg[i] == ST_PREPUSH) ? lane_pressed[i]
                                                           : !lane_pressed[i];
            count_inc[i]    = (lane_match[i] && (count_reg[i] != {CNT_W{1'b1}}))
                              ? count_reg[i] + CNT_W'(1) : count_reg[i];
            lane_confirm[i] = (count_inc[i] >= stable_count_reg);

            state_next[i] = state_reg[i];
            count_next[i] = count_reg[i];
            lane_event[i] = 1'b0;

            if (s_accept && (scan_idx_reg == SCAN_W'(i))) begin
                case (state_reg[i])
                    ST_RELEASED: begin
                        if (lane_pressed[i]) state_next[i] = ST_PREPUSH;
                    end
                    ST_PREPUSH: begin
                        if (lane_confirm[i]) begin
                            state_next[i] = ST_PUSHED;
                            count_next[i] = '0;
                            lane_event[i] = 1'b1;
                        end else begin
                            count_next[i] = count_inc[i];
                        end
                    end
                    ST_PUSHED: begin
                        if (!lane_pressed[i]) state_next[i] = ST_PREREL;
                    end
                    ST_PREREL: begin
                        if (lane_confirm[i]) begin
                            state_next[i] = ST_RELEASED;
                            count_next[i] = '0;
                        end else begin
                            count_next[i] = count_inc[i];
                        end
                    end
                    // error code: first visit lands in released, count kept
                    default: state_next[i] = ST_RELEASED;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                state_reg[i] <= ST_ERROR;
                count_reg[i] <= '0;
            end
        end else begin
            scan_idx_reg <= scan_idx_next;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                state_reg[i] <= state_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // ---------------- result fields ----------------
    logic             press_event;
    logic [EVB_W-1:0] event_button;
    logic [QST_W-1:0] query_state;
    logic [M_DATA_W-1:0] result_data;

    assign press_event  = |lane_event;
    assign event_button = scan_idle ? '0 : EVB_W'(scan_idx_reg);

    // query sees the state after this beat's update
    always_comb begin
        query_state = QST_ERROR;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if ((i < QRY_SPAN) && (query_button == QRY_W'(i))) begin
                query_state = state_code(state_next[i]);
            end
        end
    end

    assign result_data = M_DATA_W'({query_state, scan_idle, event_button, press_event});

    // ---------------- output register + skid ----------------
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] skid_data_reg;
    logic                out_pop;

    assign out_pop  = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no beat is taken while the skid entry is full
            if (out_pop) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || out_pop) begin
                out_data_reg  <= result_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= result_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/ssd_checker.sv -----
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks for the scanned switch debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssd_pkg::M_DATA_W-1:0]  m_tdata
);
    import ssd_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // the idle tick visits no button
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[0] && (m_tdata[2:1] == 2'd0))
        else $error("idle tick carries a press event or button index");

    // reported state is one of the five codes
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:4] <= QST_ERROR)
        else $error("query_state out of range");

    // reset empties the output stage and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("output stage not empty after reset");

endmodule

bind scanned_switch_debouncer_top ssd_checker u_ssd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_scanned_switch_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// tb_scanned_switch_debouncer_top
// Self-checking bench for the scanned switch debouncer. Beats go in on the
// s_ stream and every accepted beat is run through a local model of the
// round-robin scan and the per-button debounce state machine. Each result
// beat on m_ is compared field by field with the oldest predicted tick.
// Directed sequences come first (first visits, threshold zero), then
// randomized button traffic under several settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_scanned_switch_debouncer_top;
    import ssd_pkg::*;

    localparam int NB         = NUM_BUTTONS_DEF;
    localparam int CYCLE_MAX  = 400000;   // far above the slowest legal run
    localparam int TAIL_WAIT  = 8;        // wait after the queue drains

    // Result beat layout, bit 0 first: press_event, event_button, scan_idle,
    // query_state, pad
    typedef struct packed {
        logic             pad;
        logic [QST_W-1:0] qstate;
        logic             idle;
        logic [EVB_W-1:0] ebtn;
        logic             evt;
    } tick_fields_t;

    // ------------------------------------------------------------------------
    // Clock, DUT ports
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [2:0] pins, [4:3] query
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // see tick_fields_t

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    scanned_switch_debouncer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Debounce model: state per button as the reported code, confirm count,
    // scan position (NB means the idle tick comes next), settings.
    // ------------------------------------------------------------------------
    logic [QST_W-1:0] btn_code [NB];
    logic [CNT_W-1:0] btn_count[NB];
    int               scan_pos;
    logic             set_active_low;
    logic [CNT_W-1:0] set_threshold;

    tick_fields_t     pending_ticks[$];   // predicted result beats, oldest first
    int               err_count   = 0;
    int               cycle_count = 0;
    int               send_gap_pct   = 0; // chance of an idle cycle before a beat
    int               recv_stall_pct = 0; // chance m_tready is low on a cycle

    task automatic reset_model();
        for (int b = 0; b < NB; b++) begin
            btn_code[b]  = QST_ERROR;
            btn_count[b] = '0;
        end
        scan_pos       = 0;
        set_active_low = ACTIVE_LOW_RST;
        set_threshold  = STABLE_COUNT_RST;
    endtask

    // Count a matching sample (saturating), confirm once the threshold is met.
    // Count is not cleared by a bounce, only on confirm.
    function automatic logic count_confirms(int b, logic hit);
        if (hit && btn_count[b] != 8'hFF)
            btn_count[b] = btn_count[b] + 8'd1;
        if (btn_count[b] >= set_threshold) begin
            btn_count[b] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic tick_fields_t scan_tick(logic [PIN_W-1:0] pins,
                                               logic [QRY_W-1:0] qry);
        tick_fields_t r;
        int           b;
        logic         pressed;
        r = '0;
        if (scan_pos < NB) begin
            b       = scan_pos;
            pressed = set_active_low ? !pins[b] : pins[b];
            case (btn_code[b])
                QST_RELEASED: if (pressed) btn_code[b] = QST_PREPUSH;
                QST_PREPUSH: begin
                    if (count_confirms(b, pressed)) begin
                        btn_code[b] = QST_PUSHED;
                        r.evt       = 1'b1;
                    end
                end
                QST_PUSHED: if (!pressed) btn_code[b] = QST_PREREL;
                QST_PREREL: begin
                    if (count_confirms(b, !pressed))
                        btn_code[b] = QST_RELEASED;
                end
                // error code after reset: first visit just releases, pin ignored
                default: btn_code[b] = QST_RELEASED;
            endcase
            r.ebtn   = EVB_W'(b);
            scan_pos = scan_pos + 1;
        end else begin
            r.idle   = 1'b1;
            scan_pos = 0;
        end
        // query sees this tick's update; out-of-range index reads as error
        r.qstate = (qry < NB) ? btn_code[qry] : QST_ERROR;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------------

    // One input beat: optional idle gap, then hold tvalid until accepted.
    // tvalid is never dropped and raised in the same step.
    task automatic send_tick(input logic [PIN_W-1:0] pins, input logic [QRY_W-1:0] qry);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, qry, pins};
        do @(posedge aclk); while (!s_tready);
        pending_ticks.push_back(scan_tick(pins, qry));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge aclk);
    endtask

    // Both registers, back to back, only with nothing in flight
    task automatic write_settings(input logic al, input logic [CNT_W-1:0] thr);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_ACTIVE_LOW;
        cfg_wdata <= {7'd0, al};
        @(posedge aclk);
        cfg_addr  <= CFG_STABLE_COUNT;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        set_active_low = al;
        set_threshold  = thr;
    endtask

    // Random button traffic: each button has an intended press level that
    // flips now and then (toggle_pm per mille per beat); samples bounce with
    // 1-in-10 odds, and 1 beat in 10 carries fully random pins.
    task automatic drive_button_traffic(input logic al, input logic [CNT_W-1:0] thr,
                                        input int gap_pct, input int stall_pct,
                                        input int n_beats, input int toggle_pm);
        logic [PIN_W-1:0] held;
        logic [PIN_W-1:0] pins;
        write_settings(al, thr);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        held = PIN_W'($urandom_range(7));
        for (int n = 0; n < n_beats; n++) begin
            for (int b = 0; b < PIN_W; b++) begin
                if ($urandom_range(999) < toggle_pm)
                    held[b] = !held[b];
                pins[b] = held[b] ^ al;          // pressed reads !al
                if ($urandom_range(9) == 0)
                    pins[b] = !pins[b];          // bounce
            end
            if ($urandom_range(9) == 0)
                pins = PIN_W'($urandom_range(7));
            send_tick(pins, QRY_W'($urandom_range(3)));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Defaults after reset (active low, threshold 20). Unvisited buttons
    // report error, the first visit releases regardless of the pin, query 3
    // is out of range, then the idle tick wraps the scan.
    task automatic test_first_visit();
        send_tick(3'b111, 2'd1);
        send_tick(3'b000, 2'd2);
        send_tick(3'b000, 2'd3);
        send_tick(3'b000, 2'd0);
        send_tick(3'b000, 2'd0);
    endtask

    // Threshold zero with active-high wiring: one pressed visit enters
    // pre-pushed, the next confirms at once; same on the way back.
    task automatic test_instant_confirm();
        write_settings(1'b0, 8'd0);
        for (int n = 0; n < 8; n++)
            send_tick(3'b111, QRY_W'(n));
        for (int n = 0; n < 8; n++)
            send_tick(3'b000, QRY_W'(n + 1));
    endtask

    // Mixed settings and several idle/stall mixes
    task automatic test_scan_traffic();
        drive_button_traffic(1'b1, 8'd20, 0,  0,  120, 6);
        drive_button_traffic(1'b0, 8'd1,  79, 0,  120, 50);
        drive_button_traffic(1'b1, 8'd3,  0,  79, 120, 40);
        drive_button_traffic(1'b0, 8'd0,  31, 31, 100, 60);
        drive_button_traffic(1'b0, 8'd2,  79, 0,  100, 40);
        drive_button_traffic(1'b1, 8'd1,  0,  79, 100, 40);
    endtask

    // High threshold: buttons held long enough for many matching visits
    task automatic test_long_hold();
        drive_button_traffic(1'b1, 8'd80, 31, 31, 500, 1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", field, got, want,
                 cycle_count);
        err_count++;
    endtask

    always @(posedge aclk) begin
        tick_fields_t got;
        tick_fields_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_ticks.size() == 0) begin
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            end else begin
                want = pending_ticks.pop_front();
                if (got.evt !== want.evt)
                    report_mismatch("press_event", got.evt, want.evt);
                if (got.ebtn !== want.ebtn)
                    report_mismatch("event_button", got.ebtn, want.ebtn);
                if (got.idle !== want.idle)
                    report_mismatch("scan_idle", got.idle, want.idle);
                if (got.qstate !== want.qstate)
                    report_mismatch("query_state", got.qstate, want.qstate);
                if (got.pad !== want.pad)
                    report_mismatch("pad bit", got.pad, want.pad);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX) begin
            $display("[scanned_switch_debouncer_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_visit();
        test_instant_confirm();
        test_scan_traffic();
        test_long_hold();

        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (err_count == 0)
            $display("[scanned_switch_debouncer_top] OK");
        else
            $display("[scanned_switch_debouncer_top] ERROR");
        $finish;
    end

endmodule
